FILE: rtl/mrfp_pkg.sv
// Package for the meter response frame parser: frame constants, status codes,
// and the packed word types of the byte input and the reading output.
// No dependencies.
package mrfp_pkg;

  // Frame layout
  localparam int unsigned FRAME_BYTES   = 36;
  localparam int unsigned FIELD_COUNT   = 8;
  localparam int unsigned PAYLOAD_FIRST = 3;
  localparam int unsigned PAYLOAD_DEPTH = 32;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned PAY_AW        = 5;
  localparam int unsigned FIELD_W       = 3;

  // Header bytes and checksum bias
  localparam logic [7:0] HDR0     = 8'hFE;
  localparam logic [7:0] HDR1     = 8'h01;
  localparam logic [7:0] HDR2     = 8'h08;
  localparam logic [7:0] SUM_BIAS = 8'h33;

  // Result status codes
  localparam logic [1:0] STATUS_GOOD       = 2'd0;
  localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
  localparam logic [1:0] STATUS_BAD_SUM    = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } mrfp_in_t;

  typedef struct packed {
    logic [2:0]  quantity;
    logic [26:0] reading;
    logic [1:0]  status;
    logic        last;
  } mrfp_out_t;

  // Partial decode of four BCD digits: value and number of digits taken
  typedef struct packed {
    logic [13:0] value;
    logic [2:0]  count;
  } mrfp_digits_t;

endpackage

FILE: rtl/meter_response_frame_parser_top.sv
// Meter response frame parser: byte framing, header and checksum check,
// payload capture and BCD decode of the eight readings.
// Depends on mrfp_pkg.
//
// Throughput: one received byte accepted per cycle while in_ready is high; results
// leave one per cycle while out_ready is high. After the trailer byte is taken, the
// first result passes through the frame buffer and the two-register decode pipeline.
// A trailer byte waits while the previous frame's results are still in the frame
// buffer. Synchronous active-low reset returns the parser to idle with no results.
module meter_response_frame_parser_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mrfp_pkg::mrfp_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mrfp_pkg::mrfp_out_t out_data
);

  // Framing state
  logic [mrfp_pkg::IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [7:0]                 running_sum_r, running_sum_nxt;
  logic                       header_good_r, header_good_nxt;
  logic [7:0]                 payload_r [mrfp_pkg::PAYLOAD_DEPTH];

  // Frame buffer holding one finished frame
  logic                         fb_v_r, fb_v_nxt;
  logic [mrfp_pkg::FIELD_W-1:0] fb_f_r, fb_f_nxt;
  logic [1:0]                   fb_status_r;
  logic [31:0]                  fb_word_r [mrfp_pkg::FIELD_COUNT];

  // Decode stage registers
  logic                         a_v_r, a_v_nxt;
  logic [13:0]                  a_hi_r, a_lo_r;
  logic [2:0]                   a_lo_cnt_r;
  logic                         a_full_r;
  logic [mrfp_pkg::FIELD_W-1:0] a_q_r;
  logic [1:0]                   a_status_r;
  logic                         a_last_r;

  // Output register
  logic                out_v_r, out_v_nxt;
  mrfp_pkg::mrfp_out_t out_r;

  // Input-side combinational signals
  logic                        in_acc, idle, trl_cand, active, is_trailer;
  logic [mrfp_pkg::IDX_W-1:0]  idx;
  logic [7:0]                  base_sum, expect_sum;
  logic                        hg;
  logic                        pl_we;
  logic [mrfp_pkg::PAY_AW-1:0] pl_wa;
  logic                        fb_load;
  logic [1:0]                  trl_status;

  // Pipeline control
  logic out_load, a_adv, fb_take;

  // Decode signals
  logic [31:0]            field_word;
  mrfp_pkg::mrfp_digits_t hi_d, lo_d;
  logic [13:0]            pow;
  logic [27:0]            prod;
  logic [26:0]            reading_b;

  function automatic mrfp_pkg::mrfp_digits_t decode4(input logic [15:0] nibs);
    mrfp_pkg::mrfp_digits_t d;
    logic                   stop;
    logic [3:0]             nib;
    d.value = '0;
    d.count = '0;
    stop    = 1'b0;
    for (int k = 0; k < 4; k++) begin
      nib = nibs[15-4*k -: 4];
      if (!stop && (nib <= 4'd9)) begin
        d.value = (d.value << 3) + (d.value << 1) + 14'(nib);
        d.count = d.count + 3'd1;
      end else begin
        stop = 1'b1;
      end
    end
    return d;
  endfunction

  // Hold off a trailer byte while the frame buffer is still draining
  assign idle     = (byte_index_r >= mrfp_pkg::IDX_W'(mrfp_pkg::FRAME_BYTES));
  assign trl_cand = !in_data.frame_start &&
                    (byte_index_r == mrfp_pkg::IDX_W'(mrfp_pkg::FRAME_BYTES - 1));
  assign in_ready = !(fb_v_r && trl_cand);
  assign in_acc   = in_valid && in_ready;

  // Framing: header check, running sum, payload write, trailer judgement
  always_comb begin
    byte_index_nxt  = byte_index_r;
    running_sum_nxt = running_sum_r;
    header_good_nxt = header_good_r;
    pl_we           = 1'b0;
    fb_load         = 1'b0;
    trl_status      = mrfp_pkg::STATUS_GOOD;
    active          = in_acc && (in_data.frame_start || !idle);
    idx             = in_data.frame_start ? '0 : byte_index_r;
    base_sum        = in_data.frame_start ? 8'd0 : running_sum_r;
    hg              = in_data.frame_start ? 1'b1 : header_good_r;
    is_trailer      = (idx >= mrfp_pkg::IDX_W'(mrfp_pkg::FRAME_BYTES - 1));
    expect_sum      = ~base_sum + mrfp_pkg::SUM_BIAS;
    pl_wa           = mrfp_pkg::PAY_AW'(idx - mrfp_pkg::IDX_W'(mrfp_pkg::PAYLOAD_FIRST));

    if ((idx == 6'd0 && in_data.rx_byte != mrfp_pkg::HDR0) ||
        (idx == 6'd1 && in_data.rx_byte != mrfp_pkg::HDR1) ||
        (idx == 6'd2 && in_data.rx_byte != mrfp_pkg::HDR2)) begin
      hg = 1'b0;
    end

    if (!hg) begin
      trl_status = mrfp_pkg::STATUS_BAD_HEADER;
    end else if (expect_sum != in_data.rx_byte) begin
      trl_status = mrfp_pkg::STATUS_BAD_SUM;
    end

    if (active) begin
      header_good_nxt = hg;
      if (!is_trailer) begin
        running_sum_nxt = base_sum + in_data.rx_byte;
        byte_index_nxt  = idx + 6'd1;
        pl_we           = (idx >= mrfp_pkg::IDX_W'(mrfp_pkg::PAYLOAD_FIRST));
      end else begin
        running_sum_nxt = base_sum;
        byte_index_nxt  = mrfp_pkg::IDX_W'(mrfp_pkg::FRAME_BYTES);
        fb_load         = 1'b1;
      end
    end
  end

  // Pipeline advance: output register, then decode stage, then frame buffer
  assign out_load = !out_v_r || out_ready;
  assign a_adv    = !a_v_r || out_load;
  assign fb_take  = fb_v_r && a_adv;

  // Frame buffer: load on trailer, step through fields as they are taken
  always_comb begin
    fb_v_nxt = fb_v_r;
    fb_f_nxt = fb_f_r;
    if (fb_load) begin
      fb_v_nxt = 1'b1;
      fb_f_nxt = '0;
    end else if (fb_take) begin
      if (fb_status_r != mrfp_pkg::STATUS_GOOD ||
          fb_f_r == mrfp_pkg::FIELD_W'(mrfp_pkg::FIELD_COUNT - 1)) begin
        fb_v_nxt = 1'b0;
      end else begin
        fb_f_nxt = fb_f_r + 3'd1;
      end
    end
  end

  // Split the selected field into its upper and lower four digits
  assign field_word = fb_word_r[fb_f_r];
  assign hi_d       = decode4(field_word[31:16]);
  assign lo_d       = decode4(field_word[15:0]);

  assign a_v_nxt   = a_adv ? fb_v_r : a_v_r;
  assign out_v_nxt = out_load ? a_v_r : out_v_r;

  // Join the two halves: shift the upper digits by the lower digit count
  always_comb begin
    case (a_lo_cnt_r)
      3'd0:    pow = 14'd1;
      3'd1:    pow = 14'd10;
      3'd2:    pow = 14'd100;
      3'd3:    pow = 14'd1000;
      3'd4:    pow = 14'd10000;
      default: pow = 14'd1;
    endcase
  end

  assign prod = 28'(a_hi_r) * 28'(pow);

  always_comb begin
    if (a_status_r != mrfp_pkg::STATUS_GOOD) begin
      reading_b = '0;
    end else if (a_full_r) begin
      reading_b = prod[26:0] + 27'(a_lo_r);
    end else begin
      reading_b = 27'(a_hi_r);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r  <= mrfp_pkg::IDX_W'(mrfp_pkg::FRAME_BYTES);
      running_sum_r <= '0;
      header_good_r <= 1'b1;
      fb_v_r        <= 1'b0;
      fb_f_r        <= '0;
      a_v_r         <= 1'b0;
      out_v_r       <= 1'b0;
    end else begin
      byte_index_r  <= byte_index_nxt;
      running_sum_r <= running_sum_nxt;
      header_good_r <= header_good_nxt;
      fb_v_r        <= fb_v_nxt;
      fb_f_r        <= fb_f_nxt;
      a_v_r         <= a_v_nxt;
      out_v_r       <= out_v_nxt;
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (pl_we) begin
      payload_r[pl_wa] <= in_data.rx_byte;
    end
  end

  // Snapshot the payload into the frame buffer on the trailer
  always_ff @(posedge clk) begin
    if (fb_load) begin
      fb_status_r <= trl_status;
      for (int g = 0; g < mrfp_pkg::FIELD_COUNT; g++) begin
        fb_word_r[g] <= {payload_r[4*g+3], payload_r[4*g+2],
                         payload_r[4*g+1], payload_r[4*g]};
      end
    end
  end

  // Decode stage payload
  always_ff @(posedge clk) begin
    if (fb_take) begin
      a_hi_r     <= hi_d.value;
      a_lo_r     <= lo_d.value;
      a_lo_cnt_r <= lo_d.count;
      a_full_r   <= (hi_d.count == 3'd4);
      a_q_r      <= (fb_status_r == mrfp_pkg::STATUS_GOOD) ? fb_f_r : '0;
      a_status_r <= fb_status_r;
      a_last_r   <= (fb_status_r != mrfp_pkg::STATUS_GOOD) ||
                    (fb_f_r == mrfp_pkg::FIELD_W'(mrfp_pkg::FIELD_COUNT - 1));
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load && a_v_r) begin
      out_r.quantity <= a_q_r;
      out_r.reading  <= reading_b;
      out_r.status   <= a_status_r;
      out_r.last     <= a_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Byte counter never runs past the idle value
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= mrfp_pkg::IDX_W'(mrfp_pkg::FRAME_BYTES))
    else $error("byte counter out of range");

  // A trailer loads a fresh frame buffer starting at the first field
  a_fb_load: assert property (@(posedge clk) disable iff (!rst_n)
    fb_load |=> (fb_v_r && fb_f_r == '0))
    else $error("frame buffer not loaded on trailer");

  // An error frame gives one result only, from field zero
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (fb_v_r && fb_status_r != mrfp_pkg::STATUS_GOOD) |-> (fb_f_r == '0))
    else $error("error frame stepped past first field");

  // Error results are final and carry no reading
  a_err_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.status != mrfp_pkg::STATUS_GOOD) |->
      (out_r.last && out_r.reading == '0 && out_r.quantity == '0))
    else $error("malformed error result");

endmodule
